### rtl/core/imu_pkt_pkg.sv
// Shared types, constants and table functions for the inertial-sensor packet parser.
// Depends on nothing; used by imu_data_packet_parser_core.
package imu_pkt_pkg;

  localparam int NUM_KNOWN   = 19;
  localparam int TABLE_SLOTS = 32;
  localparam int IDX_W       = $clog2(TABLE_SLOTS);

  // Result kinds
  localparam logic [1:0] KIND_VALUE   = 2'd0;
  localparam logic [1:0] KIND_UNKNOWN = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  typedef enum logic [2:0] {
    CL_NONE  = 3'd0,
    CL_FLOAT = 3'd1,
    CL_U4    = 3'd2,
    CL_U2    = 3'd3,
    CL_TIME  = 3'd4,
    CL_BYTE  = 3'd5
  } cls_t;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_ID_HI  = 6'b000010,
    PH_ID_LO  = 6'b000100,
    PH_LEN    = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_IGNORE = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] field_index;
    logic [3:0]       element;
    logic [31:0]      value;
    logic             is_float;
    logic             last_in_field;
    logic [15:0]      unknown_code;
  } out_item_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } match_t;

  localparam logic [15:0] KNOWN_CODE [TABLE_SLOTS] = '{
    16'h0810, 16'h1010, 16'h1020, 16'h1060, 16'h1070, 16'h2010, 16'h2020, 16'h2030,
    16'h3010, 16'h4010, 16'h4020, 16'h4030, 16'h4040, 16'h8020, 16'h8030, 16'h8040,
    16'hE010, 16'hE020, 16'hC020, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
  };

  localparam cls_t KNOWN_CLASS [TABLE_SLOTS] = '{
    CL_FLOAT, CL_TIME,  CL_U2,    CL_U4,    CL_U4,    CL_FLOAT, CL_FLOAT, CL_FLOAT,
    CL_U4,    CL_FLOAT, CL_FLOAT, CL_FLOAT, CL_FLOAT, CL_FLOAT, CL_FLOAT, CL_FLOAT,
    CL_BYTE,  CL_U4,    CL_FLOAT, CL_NONE,  CL_NONE,  CL_NONE,  CL_NONE,  CL_NONE,
    CL_NONE,  CL_NONE,  CL_NONE,  CL_NONE,  CL_NONE,  CL_NONE,  CL_NONE,  CL_NONE
  };

  // Parallel compare against the searched part of the table; lowest index wins.
  function automatic match_t lookup(input logic [15:0] code);
    match_t m;
    m = '0;
    for (int k = NUM_KNOWN - 1; k >= 0; k--) begin
      if (KNOWN_CLASS[k] != CL_NONE && KNOWN_CODE[k] == code) begin
        m.hit = 1'b1;
        m.idx = IDX_W'(k);
      end
    end
    return m;
  endfunction

  // Byte size of value number elem in a record of class cls; 0 if none.
  function automatic logic [2:0] value_size(input cls_t cls, input logic [3:0] elem);
    logic [2:0] sz;
    case (cls)
      CL_FLOAT: sz = 3'd4;
      CL_U4:    sz = (elem == 4'd0) ? 3'd4 : 3'd0;
      CL_U2:    sz = (elem == 4'd0) ? 3'd2 : 3'd0;
      CL_TIME: begin
        if (elem == 4'd0)      sz = 3'd4;
        else if (elem == 4'd1) sz = 3'd2;
        else if (elem <= 4'd6) sz = 3'd1;
        else                   sz = 3'd0;
      end
      CL_BYTE:  sz = (elem == 4'd0) ? 3'd1 : 3'd0;
      default:  sz = 3'd0;
    endcase
    return sz;
  endfunction

endpackage

### rtl/core/imu_data_packet_parser_core.sv
// Inertial-sensor data message parser: header skip, record decode, result register.
// Depends on imu_pkt_pkg (types, code table, class sizes).
//
// Takes one message byte per cycle and gives at most one result per byte, visible in
// the cycle after the byte is accepted. The whole decode (table compare, value assembly)
// sits between the parse state registers and the output register, so a byte is taken in
// every cycle in which the output register is empty or being read out; the sustained
// rate, with the output read out every cycle, is one byte per clock. header_bytes may be
// written at any time the block is idle and takes effect on the next byte.
module imu_data_packet_parser_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  imu_pkt_pkg::in_item_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output imu_pkt_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_data
);

  logic [3:0]                      header_bytes_r;
  imu_pkt_pkg::phase_t             phase_r, phase_nxt;
  logic [3:0]                      header_count_r, header_count_nxt;
  logic [7:0]                      code_high_r, code_high_nxt;
  logic [imu_pkt_pkg::IDX_W-1:0]   matched_index_r, matched_index_nxt;
  logic [7:0]                      bytes_left_r, bytes_left_nxt;
  logic [31:0]                     value_shift_r, value_shift_nxt;
  logic [2:0]                      byte_in_value_r, byte_in_value_nxt;
  logic [3:0]                      element_count_r, element_count_nxt;
  logic                            out_valid_r, out_valid_nxt;
  imu_pkt_pkg::out_item_t          out_data_r, out_data_nxt;

  logic                            in_fire;
  logic                            emit;
  imu_pkt_pkg::out_item_t          res;
  imu_pkt_pkg::match_t             match;
  imu_pkt_pkg::cls_t               cls;
  logic [2:0]                      sz, next_sz, biv_inc;
  logic [3:0]                      elem_inc;
  logic [7:0]                      left_dec;
  logic [31:0]                     shifted;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign match    = imu_pkt_pkg::lookup({code_high_r, in_data.data_byte});
  assign cls      = imu_pkt_pkg::KNOWN_CLASS[matched_index_r];
  assign sz       = imu_pkt_pkg::value_size(cls, element_count_r);
  assign elem_inc = element_count_r + 4'd1;
  assign next_sz  = imu_pkt_pkg::value_size(cls, elem_inc);
  assign biv_inc  = byte_in_value_r + 3'd1;
  assign left_dec = bytes_left_r - 8'd1;
  assign shifted  = {value_shift_r[23:0], in_data.data_byte};

  always_comb begin
    phase_nxt         = phase_r;
    header_count_nxt  = header_count_r;
    code_high_nxt     = code_high_r;
    matched_index_nxt = matched_index_r;
    bytes_left_nxt    = bytes_left_r;
    value_shift_nxt   = value_shift_r;
    byte_in_value_nxt = byte_in_value_r;
    element_count_nxt = element_count_r;
    emit              = 1'b0;
    res               = '0;

    if (in_data.last_byte) begin
      // checksum byte: end of message, back to header skipping
      emit              = 1'b1;
      res.kind          = imu_pkt_pkg::KIND_END;
      res.value         = {24'd0, in_data.data_byte};
      phase_nxt         = imu_pkt_pkg::PH_HEADER;
      header_count_nxt  = '0;
      code_high_nxt     = '0;
      matched_index_nxt = '0;
      bytes_left_nxt    = '0;
      value_shift_nxt   = '0;
      byte_in_value_nxt = '0;
      element_count_nxt = '0;
    end else begin
      case (phase_r)
        imu_pkt_pkg::PH_HEADER: begin
          if (header_count_r < header_bytes_r) begin
            header_count_nxt = header_count_r + 4'd1;
          end else begin
            // header done; this byte is the identifier high byte
            code_high_nxt = in_data.data_byte;
            phase_nxt     = imu_pkt_pkg::PH_ID_LO;
          end
        end
        imu_pkt_pkg::PH_ID_HI: begin
          code_high_nxt = in_data.data_byte;
          phase_nxt     = imu_pkt_pkg::PH_ID_LO;
        end
        imu_pkt_pkg::PH_ID_LO: begin
          if (match.hit) begin
            matched_index_nxt = match.idx;
            phase_nxt         = imu_pkt_pkg::PH_LEN;
          end else begin
            emit             = 1'b1;
            res.kind         = imu_pkt_pkg::KIND_UNKNOWN;
            res.unknown_code = {code_high_r, in_data.data_byte};
            phase_nxt        = imu_pkt_pkg::PH_IGNORE;
          end
        end
        imu_pkt_pkg::PH_LEN: begin
          bytes_left_nxt    = in_data.data_byte;
          element_count_nxt = '0;
          byte_in_value_nxt = '0;
          value_shift_nxt   = '0;
          phase_nxt         = (in_data.data_byte == 8'd0) ? imu_pkt_pkg::PH_ID_HI
                                                          : imu_pkt_pkg::PH_DATA;
        end
        imu_pkt_pkg::PH_DATA: begin
          bytes_left_nxt = left_dec;
          if (sz != 3'd0) begin
            value_shift_nxt   = shifted;
            byte_in_value_nxt = biv_inc;
            if (biv_inc == sz) begin
              emit              = 1'b1;
              res.kind          = imu_pkt_pkg::KIND_VALUE;
              res.field_index   = matched_index_r;
              res.element       = element_count_r;
              res.value         = shifted;
              res.is_float      = (cls == imu_pkt_pkg::CL_FLOAT);
              res.last_in_field = (next_sz == 3'd0) || (left_dec < {5'd0, next_sz});
              element_count_nxt = elem_inc;
              byte_in_value_nxt = '0;
              value_shift_nxt   = '0;
            end
          end
          // declared length used up: trailing bytes already dropped
          if (left_dec == 8'd0) begin
            phase_nxt         = imu_pkt_pkg::PH_ID_HI;
            element_count_nxt = '0;
            byte_in_value_nxt = '0;
            value_shift_nxt   = '0;
          end
        end
        imu_pkt_pkg::PH_IGNORE: begin
        end
        default: begin
          phase_nxt = imu_pkt_pkg::PH_HEADER;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_fire) begin
      out_valid_nxt = emit;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_bytes_r  <= 4'd4;
      phase_r         <= imu_pkt_pkg::PH_HEADER;
      header_count_r  <= '0;
      code_high_r     <= '0;
      matched_index_r <= '0;
      bytes_left_r    <= '0;
      value_shift_r   <= '0;
      byte_in_value_r <= '0;
      element_count_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        header_bytes_r <= cfg_data;
      end
      if (in_fire) begin
        phase_r         <= phase_nxt;
        header_count_r  <= header_count_nxt;
        code_high_r     <= code_high_nxt;
        matched_index_r <= matched_index_nxt;
        bytes_left_r    <= bytes_left_nxt;
        value_shift_r   <= value_shift_nxt;
        byte_in_value_r <= byte_in_value_nxt;
        element_count_r <= element_count_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.last_byte) |=>
      (phase_r == imu_pkt_pkg::PH_HEADER && header_count_r == 4'd0))
    else $error("last byte did not restart header skipping");

  a_unknown_ignores: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind == imu_pkt_pkg::KIND_UNKNOWN) |->
      (phase_r == imu_pkt_pkg::PH_IGNORE))
    else $error("unknown identifier item without ignore phase");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind == imu_pkt_pkg::KIND_VALUE) |->
      (out_data_r.field_index < imu_pkt_pkg::IDX_W'(imu_pkt_pkg::NUM_KNOWN)))
    else $error("decoded item with table index out of range");

  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == imu_pkt_pkg::PH_DATA) |-> (bytes_left_r != 8'd0))
    else $error("record data phase with no bytes left");
`endif

endmodule

### sim/imu_data_packet_parser_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for imu_data_packet_parser_core: message bytes in, decoded items out.
// Depends on imu_pkt_pkg for the port types and result kinds; holds its own parser model.
module imu_data_packet_parser_core_tb;
  import imu_pkt_pkg::*;

  localparam int STALL_LIMIT    = 3000;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int PHASE_BYTES    = 200;
  localparam int CODES          = 19;

  localparam logic [15:0] REC_CODE [CODES] = '{
    16'h0810, 16'h1010, 16'h1020, 16'h1060, 16'h1070, 16'h2010, 16'h2020, 16'h2030,
    16'h3010, 16'h4010, 16'h4020, 16'h4030, 16'h4040, 16'h8020, 16'h8030, 16'h8040,
    16'hE010, 16'hE020, 16'hC020
  };

  localparam cls_t REC_CLASS [CODES] = '{
    CL_FLOAT, CL_TIME,  CL_U2,    CL_U4,    CL_U4,    CL_FLOAT, CL_FLOAT, CL_FLOAT,
    CL_U4,    CL_FLOAT, CL_FLOAT, CL_FLOAT, CL_FLOAT, CL_FLOAT, CL_FLOAT, CL_FLOAT,
    CL_BYTE,  CL_U4,    CL_FLOAT
  };

  // U2 with a trailing byte, zero-length record, unknown code 0x0000, checksum
  localparam logic [7:0] FIRST_MSG [16] = '{
    8'h00, 8'hFF, 8'h00, 8'hFF, 8'h10, 8'h20, 8'h03, 8'h12,
    8'h34, 8'h56, 8'h08, 8'h10, 8'h00, 8'h00, 8'h00, 8'hFF
  };

  // short float record with a trailing byte, then the last byte inside an identifier
  localparam logic [7:0] SECOND_MSG [14] = '{
    8'h00, 8'hFF, 8'h00, 8'hFF, 8'h20, 8'h10, 8'h05, 8'h3F,
    8'h80, 8'h00, 8'h00, 8'h81, 8'h40, 8'h80
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data = '0;

  in_item_t  pending_bytes [$];
  out_item_t results_due [$];
  int        errors = 0;
  int        gen_hdr = 4;
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_cycles = 0;
  bit        squeeze_armed = 1'b0;
  bit        squeezed = 1'b0;
  int        hold_left = 0;
  logic [31:0] rx_cycle = '0;

  // parser model state
  logic [3:0]       hdr_len = 4'd4;
  logic [3:0]       hdr_seen;
  phase_t           parse_ph;
  logic [7:0]       id_hi;
  logic [IDX_W-1:0] rec_idx;
  logic [7:0]       rec_left;
  logic [31:0]      acc;
  logic [2:0]       acc_bytes;
  logic [3:0]       elem_no;

  imu_data_packet_parser_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void restart_parse();
    hdr_seen  = '0;
    parse_ph  = PH_HEADER;
    id_hi     = '0;
    rec_idx   = '0;
    rec_left  = '0;
    acc       = '0;
    acc_bytes = '0;
    elem_no   = '0;
  endfunction

  function automatic logic [2:0] element_bytes(input cls_t c, input logic [3:0] e);
    case (c)
      CL_FLOAT: return 3'd4;
      CL_U4:    return (e == 4'd0) ? 3'd4 : 3'd0;
      CL_U2:    return (e == 4'd0) ? 3'd2 : 3'd0;
      CL_TIME:  return (e == 4'd0) ? 3'd4 : (e == 4'd1) ? 3'd2 : (e <= 4'd6) ? 3'd1 : 3'd0;
      CL_BYTE:  return (e == 4'd0) ? 3'd1 : 3'd0;
      default:  return 3'd0;
    endcase
  endfunction

  // Advances the model by one byte; returns 1 when the byte yields a result.
  function automatic bit decode_byte(input in_item_t it, output out_item_t res);
    logic [15:0] code;
    logic [2:0]  sz;
    logic [2:0]  nsz;
    cls_t        c;
    bit          got;
    int          k;
    res = '0;
    got = 1'b0;
    if (it.last_byte) begin
      res.kind  = KIND_END;
      res.value = {24'd0, it.data_byte};
      restart_parse();
      return 1'b1;
    end
    if (parse_ph == PH_HEADER) begin
      if (hdr_seen < hdr_len) begin
        hdr_seen = hdr_seen + 4'd1;
        return 1'b0;
      end
      parse_ph = PH_ID_HI;
    end
    case (parse_ph)
      PH_ID_HI: begin
        id_hi = it.data_byte;
        parse_ph = PH_ID_LO;
      end
      PH_ID_LO: begin
        code = {id_hi, it.data_byte};
        parse_ph = PH_IGNORE;
        for (k = 0; k < NUM_KNOWN && k < CODES; k++) begin
          if (parse_ph == PH_IGNORE && REC_CODE[k] == code) begin
            rec_idx = IDX_W'(k);
            parse_ph = PH_LEN;
          end
        end
        if (parse_ph == PH_IGNORE) begin
          res.kind = KIND_UNKNOWN;
          res.unknown_code = code;
          got = 1'b1;
        end
      end
      PH_LEN: begin
        rec_left  = it.data_byte;
        elem_no   = '0;
        acc_bytes = '0;
        acc       = '0;
        parse_ph  = (it.data_byte == 8'd0) ? PH_ID_HI : PH_DATA;
      end
      PH_DATA: begin
        c = REC_CLASS[rec_idx];
        sz = element_bytes(c, elem_no);
        rec_left = rec_left - 8'd1;
        if (sz != 3'd0) begin
          acc = {acc[23:0], it.data_byte};
          acc_bytes = acc_bytes + 3'd1;
          if (acc_bytes == sz) begin
            nsz = element_bytes(c, elem_no + 4'd1);
            res.kind          = KIND_VALUE;
            res.field_index   = rec_idx;
            res.element       = elem_no;
            res.value         = acc;
            res.is_float      = (c == CL_FLOAT);
            res.last_in_field = (nsz == 3'd0) || (rec_left < nsz);
            elem_no   = elem_no + 4'd1;
            acc_bytes = '0;
            acc       = '0;
            got = 1'b1;
          end
        end
        // bytes past what the class decodes are eaten until the declared length runs out
        if (rec_left == 8'd0) begin
          parse_ph  = PH_ID_HI;
          elem_no   = '0;
          acc_bytes = '0;
          acc       = '0;
        end
      end
      default: ;
    endcase
    return got;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic l);
    in_item_t it;
    it.data_byte = b;
    it.last_byte = l;
    pending_bytes.push_back(it);
  endfunction

  // Mostly the exact size of the class, sometimes empty, short, padded or very long.
  function automatic int record_length(input cls_t c);
    int full;
    case (c)
      CL_FLOAT: full = 4 * $urandom_range(1, 4);
      CL_U4:    full = 4;
      CL_U2:    full = 2;
      CL_TIME:  full = 11;
      default:  full = 1;
    endcase
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return $urandom_range(0, full - 1);
      2:       return full + $urandom_range(1, 6);
      3:       return (c == CL_FLOAT) ? $urandom_range(60, 72) : $urandom_range(0, 24);
      default: return full;
    endcase
  endfunction

  function automatic int queue_message();
    logic [7:0]  body [$];
    logic [15:0] code;
    int          nrec;
    int          len;
    int          cut;
    int          k;
    int          r;
    for (k = 0; k < gen_hdr; k++) body.push_back(rand_byte());
    nrec = $urandom_range(0, 4);
    for (r = 0; r < nrec; r++) begin
      if ($urandom_range(0, 11) == 0) begin
        code = {rand_byte(), rand_byte()};
        body.push_back(code[15:8]);
        body.push_back(code[7:0]);
        repeat ($urandom_range(0, 6)) body.push_back(rand_byte());
        break;
      end
      k = $urandom_range(0, CODES - 1);
      len = record_length(REC_CLASS[k]);
      body.push_back(REC_CODE[k][15:8]);
      body.push_back(REC_CODE[k][7:0]);
      body.push_back(8'(len));
      repeat (len) body.push_back(rand_byte());
    end
    // now and then the checksum byte cuts the message short
    cut = body.size();
    if (cut != 0 && $urandom_range(0, 9) == 0) cut = $urandom_range(0, cut - 1);
    for (k = 0; k < cut; k++) queue_byte(body[k], 1'b0);
    queue_byte(rand_byte(), 1'b1);
    return cut + 1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic wait_for_drain();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_header_len(input logic [3:0] v);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    hdr_len = v;
  endtask

  always @(posedge clk) begin : byte_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        in_data  <= pending_bytes.pop_front();
        in_valid <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_sink
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_cycle  <= '0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (squeeze_armed && !squeezed && pending_bytes.size() > 100) begin
        // long hold-off so the output backs up into the input
        squeezed  <= 1'b1;
        hold_left <= SQUEEZE_CYCLES;
        out_ready <= 1'b0;
      end else begin
        case (rx_cycle[8:6])
          3'd0, 3'd1: out_ready <= 1'b1;
          3'd2:       out_ready <= rx_cycle[0];
          3'd3:       out_ready <= ($urandom_range(0, 3) != 0);
          3'd4:       out_ready <= 1'($urandom_range(0, 1));
          3'd5:       out_ready <= (rx_cycle[2:0] == 3'd0);
          default:    out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : scoreboard
    out_item_t want;
    out_item_t pred;
    if (rst_n) begin
      // result leaving now belongs to an earlier byte, so check before predicting
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, actual %h", $time, out_data);
        end else begin
          want = results_due.pop_front();
          check_field("kind", want.kind, out_data.kind);
          check_field("field_index", want.field_index, out_data.field_index);
          check_field("element", want.element, out_data.element);
          check_field("value", want.value, out_data.value);
          check_field("is_float", want.is_float, out_data.is_float);
          check_field("last_in_field", want.last_in_field, out_data.last_in_field);
          check_field("unknown_code", want.unknown_code, out_data.unknown_code);
        end
      end
      if (in_valid && in_ready) begin
        if (decode_byte(in_data, pred)) results_due.push_back(pred);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int         p;
    int         sent;
    logic [3:0] setting;
    restart_parse();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (FIRST_MSG[k]) queue_byte(FIRST_MSG[k], k == $size(FIRST_MSG) - 1);
    foreach (SECOND_MSG[k]) queue_byte(SECOND_MSG[k], k == $size(SECOND_MSG) - 1);
    for (p = 0; p < 6; p++) begin
      case (p)
        0:       setting = 4'd0;
        1:       setting = 4'd15;
        2:       setting = 4'd3;
        3:       setting = 4'd9;
        4:       setting = 4'd1;
        default: setting = 4'($urandom_range(0, 15));
      endcase
      write_header_len(setting);
      gen_hdr = setting;
      @(negedge clk);
      if (p == 3) squeeze_armed = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) sent += queue_message();
      // leave a message open in its header; the next write shortens the header under it
      if (p == 1) repeat (6) queue_byte(rand_byte(), 1'b0);
    end
    wait_for_drain();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
rtl/core/imu_pkt_pkg.sv
rtl/core/imu_data_packet_parser_core.sv
sim/imu_data_packet_parser_core_tb.sv
